// ----- sv/rpy_pkg.sv -----
// ----------------------------------------------------------------------------
// rpy_pkg
// Shared constants and pipeline sideband types for the RPY pair block.
// ----------------------------------------------------------------------------
package rpy_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W       = 32;
  localparam int ELEM_W        = 32;
  localparam int RADIUS_W      = 31;
  localparam int MAG_W         = 31;
  localparam int NUM_AXES      = 3;
  localparam int IN_TDATA_W    = 2 * NUM_AXES * COORD_W;
  localparam int OUT_TDATA_W   = NUM_AXES * NUM_AXES * ELEM_W;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 31'd65536;

  // carried alongside the square root iterations
  typedef struct packed {
    logic                  same;
    logic                  sh;
    logic [2:0]            neg;
    logic [2:0][MAG_W-1:0] mag;
  } rpy_side_t;

  // carried alongside the divider and the tensor stages
  typedef struct packed {
    logic       ident;
    logic       far;
    logic [2:0] neg;
  } rpy_flags_t;

endpackage

// ----- sv/rotne_prager_pair_block_unit.sv -----
// ----------------------------------------------------------------------------
// rotne_prager_pair_block_unit
// Pipelined Rotne-Prager-Yamakawa 3x3 pair block in fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one bead pair per transaction: tdata holds the six
//   coordinates, tuser[0] flags a same-bead pair (identity block).
//   m_axis returns the nine tensor entries of that pair, row major.
//   bead_radius_wr_en/bead_radius_wr_data set the bead radius; write it only
//   while no pair is in flight.
// Throughput: one pair per cycle while no result is stalled on m_axis.
// Pipeline: the depth is set by the 32-step integer square root and the
//   FRAC_BITS + 2 step restoring dividers (FRAC_BITS defaults to 16), one
//   step per stage.
// Stall: the whole pipeline freezes while a result waits on m_axis_tready;
//   s_axis_tready is low exactly then, so nothing is dropped or repeated.
// Reset: clears all valid bits and sets the radius to 65536.
// ----------------------------------------------------------------------------
module rotne_prager_pair_block_unit #(
  parameter int FRAC_BITS = rpy_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             bead_radius_wr_en,
  input  logic [rpy_pkg::RADIUS_W-1:0]     bead_radius_wr_data,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z
  input  logic [rpy_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // same_bead
  input  logic [0:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // elem_xx, elem_xy, elem_xz, elem_yx, elem_yy, elem_yz, elem_zx, elem_zy, elem_zz
  output logic [rpy_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  localparam int F     = FRAC_BITS;
  localparam int SQ_N  = 32;           // square root steps
  localparam int QW    = F + 2;        // quotient width = divider steps
  localparam int DW    = 34;           // divisor width
  localparam int XW    = DW + QW;      // divider working register
  localparam int SW    = F + 2;        // scalar and unit vector width
  localparam int PW    = 2 * SW;       // product width
  localparam int DTW   = F + 3;        // diagonal term width
  localparam int IW    = F + 4;        // inner term width
  localparam int PPW   = SW + 1 + IW;  // final product width
  localparam int CW    = F + 6;        // scalar constant helper width
  localparam int EW    = rpy_pkg::ELEM_W;
  localparam int LAT   = 45 + QW;
  localparam logic [63:0]   HALF64 = 64'(1) << (F - 1);
  localparam longint unsigned M3_L = ((64'd1 << (F + 1)) + 64'd2) / 64'd3;
  localparam logic [F-1:0]  M3     = F'(M3_L);
  localparam logic [SW-1:0] ONE_S  = SW'(1) << F;
  localparam logic [DTW-1:0] ONE_D = DTW'(1) << F;
  localparam logic [EW-1:0] ONE_E  = EW'(1) << F;
  localparam logic [CW-1:0] C16    = CW'(16);
  localparam logic [CW-1:0] C2     = CW'(2);

  // round to nearest, halves away from zero, after dropping F bits
  function automatic logic signed [63:0] qround(input logic signed [63:0] p);
    logic [63:0] mag;
    logic [63:0] r;
    mag = p[63] ? 64'(-p) : 64'(p);
    r = (mag + HALF64) >> F;
    qround = p[63] ? -$signed(r) : $signed(r);
  endfunction

  logic                         en;
  logic [LAT-1:0]               vp;
  logic [rpy_pkg::RADIUS_W-1:0] bead_radius;

  assign en            = ~vp[LAT-1] | m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vp[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vp          <= '0;
      bead_radius <= rpy_pkg::RADIUS_RESET;
    end else begin
      if (en) vp <= {vp[LAT-2:0], s_axis_tvalid};
      if (bead_radius_wr_en) bead_radius <= bead_radius_wr_data;
    end
  end

  // ---- stage 1: differences
  logic signed [31:0] in_first [3];
  logic signed [31:0] in_second [3];
  logic signed [32:0] d1 [3];
  logic               same1;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      in_first[k]  = s_axis_tdata[32*k +: 32];
      in_second[k] = s_axis_tdata[96 + 32*k +: 32];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      same1 <= s_axis_tuser[0];
      for (int k = 0; k < 3; k++)
        d1[k] <= {in_first[k][31], in_first[k]} - {in_second[k][31], in_second[k]};
    end
  end

  // ---- stage 2: magnitudes and range pre-shift
  logic [32:0]        negd [3];
  logic [31:0]        mag2c [3];
  logic               big;
  rpy_pkg::rpy_side_t side2c, side2, side3;

  always_comb begin
    big = 1'b0;
    for (int k = 0; k < 3; k++) begin
      negd[k]  = 33'(0) - d1[k];
      mag2c[k] = d1[k][32] ? negd[k][31:0] : d1[k][31:0];
      big      = big | mag2c[k][31];
    end
    side2c.same = same1;
    side2c.sh   = big;
    for (int k = 0; k < 3; k++) begin
      side2c.neg[k] = d1[k][32];
      side2c.mag[k] = big ? {1'b0, mag2c[k][31:2]} : mag2c[k][30:0];
    end
  end

  // ---- stage 3: squares, stage 4: sum into the square root pipe
  logic [61:0]        sq3 [3];
  logic [63:0]        rx [0:SQ_N-1];
  logic [63:0]        rr [0:SQ_N];
  rpy_pkg::rpy_side_t rs [0:SQ_N];
  logic [63:0]        trial [0:SQ_N-1];
  logic [63:0]        rx_n [0:SQ_N-1];
  logic [63:0]        rr_n [0:SQ_N-1];

  always_comb begin
    for (int j = 0; j < SQ_N; j++) begin
      trial[j] = rr[j] + (64'(1) << (62 - 2*j));
      if (rx[j] >= trial[j]) begin
        rx_n[j] = rx[j] - trial[j];
        rr_n[j] = (rr[j] >> 1) + (64'(1) << (62 - 2*j));
      end else begin
        rx_n[j] = rx[j];
        rr_n[j] = rr[j] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side2 <= side2c;
      for (int k = 0; k < 3; k++)
        sq3[k] <= side2.mag[k] * side2.mag[k];
      side3 <= side2;
      rx[0] <= 64'(sq3[0]) + 64'(sq3[1]) + 64'(sq3[2]);
      rr[0] <= '0;
      rs[0] <= side3;
      for (int j = 0; j < SQ_N; j++) begin
        if (j + 1 < SQ_N) rx[j+1] <= rx_n[j];
        rr[j+1] <= rr_n[j];
        rs[j+1] <= rs[j];
      end
    end
  end

  // ---- divider setup: three unit vector lanes and one scalar lane
  logic [31:0]         m5;
  logic [DW-1:0]       n5;
  logic                far5;
  logic [XW-1:0]       dz0c [4];
  logic [DW-1:0]       dd0c [4];
  rpy_pkg::rpy_flags_t f5c;

  always_comb begin
    m5   = rr[SQ_N][31:0];
    n5   = rs[SQ_N].sh ? {m5, 2'b00} : {2'b00, m5};
    far5 = n5 > {2'b00, bead_radius, 1'b0};
    for (int l = 0; l < 3; l++) begin
      dz0c[l] = (XW'(rs[SQ_N].mag[l]) << F) + XW'(m5 >> 1);
      dd0c[l] = {2'b00, m5};
    end
    // far: t = a / n, near: s = n / a
    dz0c[3] = (XW'(far5 ? {1'b0, bead_radius} : n5[31:0]) << F)
            + XW'(far5 ? (n5 >> 1) : {3'b000, bead_radius >> 1});
    dd0c[3] = far5 ? n5 : {3'b000, bead_radius};
    f5c.ident = rs[SQ_N].same | (m5 == 32'd0);
    f5c.far   = far5;
    f5c.neg   = rs[SQ_N].neg;
  end

  // ---- restoring dividers, one quotient bit per stage
  logic [XW-1:0]       dz [0:QW][4];
  logic [DW-1:0]       dd [0:QW-1][4];
  rpy_pkg::rpy_flags_t df [0:QW];
  logic [DW:0]         tdiv [0:QW-1][4];
  logic [DW:0]         rdiv [0:QW-1][4];
  logic                gdiv [0:QW-1][4];
  logic [XW-1:0]       dz_n [0:QW-1][4];

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      for (int l = 0; l < 4; l++) begin
        tdiv[k][l] = dz[k][l][XW-1:QW-1];
        gdiv[k][l] = tdiv[k][l] >= {1'b0, dd[k][l]};
        rdiv[k][l] = gdiv[k][l] ? tdiv[k][l] - {1'b0, dd[k][l]} : tdiv[k][l];
        dz_n[k][l] = {rdiv[k][l][DW-1:0], dz[k][l][QW-2:0], gdiv[k][l]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 4; l++) begin
        dz[0][l] <= dz0c[l];
        dd[0][l] <= dd0c[l];
      end
      df[0] <= f5c;
      for (int k = 0; k < QW; k++) begin
        for (int l = 0; l < 4; l++) begin
          dz[k+1][l] <= dz_n[k][l];
          if (k + 1 < QW) dd[k+1][l] <= dd[k][l];
        end
        df[k+1] <= df[k];
      end
    end
  end

  // ---- tensor stages
  logic signed [SW-1:0]  e6 [3];
  logic [SW-1:0]         scal6;
  rpy_pkg::rpy_flags_t   f6, f7, f8, f9, f10, f11, f12;
  logic signed [PW-1:0]  p7 [3][3];
  logic [PW-1:0]         tt7;
  logic [SW-1:0]         k7, w7, pref7, k8, w8, pref8, k9, pref9, pref10, pref11;
  logic [CW-1:0]         s9c, s3c;
  logic signed [SW-1:0]  u8 [3][3];
  logic signed [SW-1:0]  u9 [3][3];
  logic [SW-1:0]         t2_8;
  logic [SW:0]           x3c;
  logic [SW+F:0]         p3_9;
  logic [SW-1:0]         multc;
  logic signed [SW-1:0]  coef9;
  logic [DTW-1:0]        dtc;
  logic signed [PW-1:0]  pc10 [3][3];
  logic signed [DTW-1:0] dterm10;
  logic signed [IW-1:0]  inner11 [3][3];
  logic signed [IW-1:0]  inner12 [3][3];
  logic signed [PPW-1:0] pp12 [3][3];
  logic [EW-1:0]         elem_c [3][3];
  logic [rpy_pkg::OUT_TDATA_W-1:0] odata;

  always_comb begin
    s9c   = (CW'(scal6) << 3) + CW'(scal6) + C16;
    s3c   = (CW'(scal6) << 1) + CW'(scal6);
    x3c   = {t2_8, 1'b1};
    multc = ONE_S - {t2_8[SW-2:0], 1'b0};
    dtc   = f9.far ? (ONE_D + DTW'(p3_9 >> (F + 1))) : (ONE_D - DTW'(k9));
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (f12.ident)
          elem_c[i][j] = (i == j) ? ONE_E : '0;
        else if (f12.far)
          elem_c[i][j] = EW'(qround(64'(pp12[i][j])));
        else
          elem_c[i][j] = EW'(inner12[i][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++)
        e6[l] <= df[QW].neg[l] ? -$signed(dz[QW][l][QW-1:0]) : $signed(dz[QW][l][QW-1:0]);
      scal6 <= dz[QW][3][QW-1:0];
      f6    <= df[QW];

      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          p7[i][j] <= e6[i] * e6[j];
      tt7   <= scal6 * scal6;
      k7    <= SW'(s9c >> 5);
      w7    <= SW'((s3c + C16) >> 5);
      pref7 <= SW'((s3c + C2) >> 2);
      f7    <= f6;

      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          u8[i][j] <= SW'(qround(64'(p7[i][j])));
      t2_8  <= SW'((64'(tt7) + HALF64) >> F);
      k8    <= k7;
      w8    <= w7;
      pref8 <= pref7;
      f8    <= f7;

      // floor(x / 3) as a reciprocal multiply
      p3_9  <= x3c * M3;
      coef9 <= f8.far ? $signed(multc) : $signed(w8);
      u9    <= u8;
      k9    <= k8;
      pref9 <= pref8;
      f9    <= f8;

      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          pc10[i][j] <= coef9 * u9[i][j];
      dterm10 <= $signed(dtc);
      pref10  <= pref9;
      f10     <= f9;

      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          inner11[i][j] <= IW'(qround(64'(pc10[i][j])))
                         + ((i == j) ? IW'(dterm10) : IW'(0));
      pref11 <= pref10;
      f11    <= f10;

      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          pp12[i][j] <= $signed({1'b0, pref11}) * inner11[i][j];
      inner12 <= inner11;
      f12     <= f11;

      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          odata[EW*(3*i + j) +: EW] <= elem_c[i][j];
    end
  end

  assign m_axis_tdata = odata;

endmodule

// ----- sv/rpy_checker.sv -----
// ----------------------------------------------------------------------------
// rpy_checker
// Port-level checks for the RPY pair block, bound to the top level.
// ----------------------------------------------------------------------------
module rpy_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [rpy_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  // input side is held off only by a stalled result
  a_ready_follows: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("s_axis_tready does not track output stall");

  // the pair block is symmetric
  a_symmetric: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[63:32] == m_axis_tdata[127:96]) &&
                      (m_axis_tdata[95:64] == m_axis_tdata[223:192]) &&
                      (m_axis_tdata[191:160] == m_axis_tdata[255:224]))
    else $error("result block not symmetric");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result transaction changed");

  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind rotne_prager_pair_block_unit rpy_checker u_rpy_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
